// File: design/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

  localparam int SINE_DEPTH = 256;

  // angles are Q6.12 radians
  localparam int TWO_PI_Q   = 25736;
  localparam int PI_Q       = 12868;
  localparam int THIRD_Q    = 8579;
  localparam int TWO_THIRD_Q = 17157;

  // reciprocal constants for exact division by constants
  localparam logic [19:0] RECIP_50   = 20'd671089;         // x*4096/50 = (x*R)>>13
  localparam logic [33:0] RECIP_1000 = 34'd8796093023;     // t*4096/1000 = (t*R)>>31
  localparam logic [23:0] RECIP_TURN2 = 24'd10680678;      // (v>>4)/3217 = (.*R)>>35
  localparam logic [24:0] RECIP_POS  = 25'd21361355;       // v/3217 = (v*R)>>36

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [12:0] sine_tab_t [0:SINE_DEPTH];

  typedef struct packed {
    logic [14:0] cx;
    logic [14:0] cy;
    logic [14:0] r1;
    logic [15:0] r2;
  } side_t;

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] q12;
    for (int p = 0; p <= SINE_DEPTH; p++) begin
      x    = (64'(p) * HALF_PI_Q30) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd110;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd72;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
      s    = (x * term) >> 30;
      q12  = (s + (64'd1 << 17)) >> 18;
      if (q12 > 64'd4096) begin
        q12 = 64'd4096;
      end
      tab[p] = q12[12:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

// File: design/ppc_sqrt.sv
`default_nettype none
// bit-serial restoring square root, one result bit per stage
module ppc_sqrt
  import ppc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [29:0] sq_in,
  output logic      [14:0] root_out
);

  localparam int STAGES = 15;

  logic [29:0] op_r  [0:STAGES-1];
  logic [29:0] res_r [0:STAGES-1];

  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [29:0] ONE = 30'(1) << (2 * (STAGES - 1 - i));
      logic [29:0] op_in;
      logic [29:0] res_in;
      logic [29:0] trial;
      logic [29:0] op_nxt;
      logic [29:0] res_nxt;

      if (i == 0) begin : g_first
        assign op_in  = sq_in;
        assign res_in = '0;
      end else begin : g_next
        assign op_in  = op_r[i-1];
        assign res_in = res_r[i-1];
      end

      always_comb begin
        trial = res_in + ONE;
        if (op_in >= trial) begin
          op_nxt  = op_in - trial;
          res_nxt = (res_in >> 1) + ONE;
        end else begin
          op_nxt  = op_in;
          res_nxt = res_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          op_r[i]  <= op_nxt;
          res_r[i] <= res_nxt;
        end
      end
    end
  endgenerate

  assign root_out = res_r[STAGES-1][14:0];

endmodule
`default_nettype wire

// File: design/ppc_sine.sv
`default_nettype none
// two-stage sine: angle -> table position, then quarter-wave lookup
module ppc_sine
  import ppc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic        [16:0] angle,
  output logic signed      [13:0] sine
);

  logic [23:0] num;
  logic [48:0] prod_r;
  logic [9:0]  pos;
  logic [8:0]  idx;
  logic [12:0] mag;
  logic signed [13:0] sine_nxt;
  logic signed [13:0] sine_r;

  // round(a*1024/2pi) = floor((128a + 1608) / 3217), low 10 bits give the turn position
  assign num = {angle, 7'd0} + 24'd1608;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 49'(num) * 49'(RECIP_POS);
    end
  end

  always_comb begin
    pos = prod_r[45:36];
    if (pos[8]) begin
      idx = 9'(SINE_DEPTH) - {1'b0, pos[7:0]};
    end else begin
      idx = {1'b0, pos[7:0]};
    end
    mag = SINE_TAB[idx];
    // magnitude reaches 4096, so one extra bit keeps +4096 positive
    if (pos[9]) begin
      sine_nxt = -$signed({1'b0, mag});
    end else begin
      sine_nxt = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r <= sine_nxt;
    end
  end

  assign sine = sine_r;

endmodule
`default_nettype wire

// File: design/plasma_pixel_color.sv
`default_nettype none
// Plasma color generator, fully pipelined.
// Throughput: one pixel per cycle; a stall on out_tready freezes the whole pipeline.
// The 15-stage square root sets most of the depth.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module plasma_pixel_color
  import ppc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // pixel_x[7:0], pixel_y[15:8], time_ms[39:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  localparam int DEPTH   = 28;
  localparam int SIDE_DL = 12;

  logic [DEPTH-1:0] vld_r;
  logic             en;

  assign en        = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // stage 1: scaling products
  logic [27:0] cxm_r, cym_r;
  logic [45:0] thm_r, tlm_r;
  // stage 2
  logic [14:0] cx2_r, cy2_r;
  logic [26:0] tf2_r;
  logic [57:0] tsum;
  // stage 3
  logic [29:0] sqx_r, sqy_r;
  logic [46:0] tqp_r;
  logic [14:0] cx3_r, cy3_r;
  logic [26:0] tf3_r;
  // stage 4
  logic [29:0] n4_r;
  logic [10:0] tq4_r;
  logic [14:0] cx4_r, cy4_r;
  logic [26:0] tf4_r;
  // stage 5..7
  logic [26:0] tqm5_r, tf5_r;
  logic [14:0] cx5_r, cy5_r;
  logic [15:0] r2_6_r;
  logic [14:0] cx6_r, cy6_r;
  side_t       side7_r;
  side_t       side_dl_r [0:SIDE_DL-1];
  logic [14:0] rad;

  always_ff @(posedge clk) begin
    if (en) begin
      cxm_r <= 28'(in_tdata[7:0]) * 28'(RECIP_50);
      cym_r <= 28'(in_tdata[15:8]) * 28'(RECIP_50);
      thm_r <= 46'(in_tdata[39:28]) * 46'(RECIP_1000);
      tlm_r <= 46'(in_tdata[27:16]) * 46'(RECIP_1000);
    end
  end

  assign tsum = {thm_r, 12'd0} + 58'(tlm_r);

  always_ff @(posedge clk) begin
    if (en) begin
      cx2_r <= cxm_r[27:13];
      cy2_r <= cym_r[27:13];
      tf2_r <= tsum[57:31];

      sqx_r <= 30'(cx2_r) * 30'(cx2_r);
      sqy_r <= 30'(cy2_r) * 30'(cy2_r);
      tqp_r <= 47'(tf2_r[26:4]) * 47'(RECIP_TURN2);
      cx3_r <= cx2_r;
      cy3_r <= cy2_r;
      tf3_r <= tf2_r;

      n4_r  <= sqx_r + sqy_r;
      tq4_r <= tqp_r[45:35];
      cx4_r <= cx3_r;
      cy4_r <= cy3_r;
      tf4_r <= tf3_r;

      tqm5_r <= 27'(tq4_r) * 27'(2 * TWO_PI_Q);
      tf5_r  <= tf4_r;
      cx5_r  <= cx4_r;
      cy5_r  <= cy4_r;

      // time angle reduced modulo a double turn
      r2_6_r <= 16'(tf5_r - tqm5_r);
      cx6_r  <= cx5_r;
      cy6_r  <= cy5_r;

      side7_r.cx <= cx6_r;
      side7_r.cy <= cy6_r;
      side7_r.r2 <= r2_6_r;
      if (r2_6_r >= 16'(TWO_PI_Q)) begin
        side7_r.r1 <= 15'(r2_6_r - 16'(TWO_PI_Q));
      end else begin
        side7_r.r1 <= r2_6_r[14:0];
      end

      side_dl_r[0] <= side7_r;
      for (int k = 1; k < SIDE_DL; k++) begin
        side_dl_r[k] <= side_dl_r[k-1];
      end
    end
  end

  ppc_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .sq_in    (n4_r),
    .root_out (rad)
  );

  // stage 20: wave angles
  side_t       sd;
  logic [16:0] ang_r [0:3];
  logic signed [13:0] wave [0:3];

  assign sd = side_dl_r[SIDE_DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[0] <= 17'(sd.cx) + 17'(sd.r1);
      ang_r[1] <= 17'(sd.cy) + 17'(sd.r2[15:1]);
      ang_r[2] <= 17'((18'(sd.cx) + 18'(sd.cy) + 18'(sd.r2)) >> 1);
      ang_r[3] <= 17'(rad) + 17'(sd.r1);
    end
  end

  genvar w;
  generate
    for (w = 0; w < 4; w++) begin : g_wave
      ppc_sine u_sine (
        .clk   (clk),
        .en    (en),
        .angle (ang_r[w]),
        .sine  (wave[w])
      );
    end
  endgenerate

  // stages 23..25: sum, scale by pi, color phases
  logic signed [15:0] v_r;
  logic signed [29:0] p_r;
  logic signed [17:0] ph;
  logic [16:0]        cang_r [0:2];
  logic signed [13:0] csin [0:2];
  logic [7:0]         chan_r [0:2];

  assign ph = 18'(p_r >>> 12);

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= 16'(wave[0]) + 16'(wave[1]) + 16'(wave[2]) + 16'(wave[3]);
      p_r <= 30'(v_r) * 30'sd12868;
      // offset by a double turn keeps the phase non-negative
      cang_r[0] <= 17'(ph + 18'sd51472);
      cang_r[1] <= 17'(ph + 18'sd51472 + 18'(THIRD_Q));
      cang_r[2] <= 17'(ph + 18'sd51472 + 18'(TWO_THIRD_Q));
    end
  end

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_chan
      logic [13:0] lvl;
      logic [21:0] scl;

      ppc_sine u_sine (
        .clk   (clk),
        .en    (en),
        .angle (cang_r[c]),
        .sine  (csin[c])
      );

      assign lvl = 14'(csin[c]) + 14'd4096;
      assign scl = 22'(lvl) * 22'd255;

      always_ff @(posedge clk) begin
        if (en) begin
          chan_r[c] <= scl[20:13];
        end
      end
    end
  endgenerate

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {chan_r[2], chan_r[1], chan_r[0]};

endmodule
`default_nettype wire

// File: sim/plasma_pixel_color_tb.sv
`timescale 1ns / 1ps
module plasma_pixel_color_tb;
  import ppc_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [23:0] time_ms;
    logic [7:0]  pixel_y;
    logic [7:0]  pixel_x;
  } pixel_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  plasma_pixel_color i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pixel_t pending_pixels[$];
  color_t expected_colors[$];
  int     error_count;
  int     quiet_cycles;
  bit     hold_sender;
  int     burst_left;
  int     gap_left;
  int     stall_phase;
  longint quarter_sine[0:SINE_DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // quarter-wave table, Q1.12, built from a Taylor series in Q30
  function automatic void fill_quarter_sine();
    longint unsigned x, x2, term, s, q;
    longint unsigned dens[5];
    dens = '{110, 72, 42, 20, 6};
    for (int p = 0; p <= SINE_DEPTH; p++) begin
      x = (longint'(p) * 64'd1686629713) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = 64'd1073741824;
      for (int k = 0; k < 5; k++)
        term = 64'd1073741824 - ((x2 * term) >> 30) / dens[k];
      s = (x * term) >> 30;
      q = (s + (64'd1 << 17)) >> 18;
      if (q > 4096) q = 4096;
      quarter_sine[p] = q;
    end
  endfunction

  function automatic longint sine_at(longint angle);
    longint a, pos, quad, r;
    a = angle % TWO_PI_Q;
    if (a < 0) a += TWO_PI_Q;
    pos = ((a * 4 * SINE_DEPTH) + TWO_PI_Q / 2) / TWO_PI_Q;
    pos = pos % (4 * SINE_DEPTH);
    quad = pos / SINE_DEPTH;
    r = pos % SINE_DEPTH;
    case (quad)
      0: return quarter_sine[r];
      1: return quarter_sine[SINE_DEPTH - r];
      2: return -quarter_sine[r];
      default: return -quarter_sine[SINE_DEPTH - r];
    endcase
  endfunction

  function automatic longint isqrt_newton(longint unsigned n);
    longint unsigned g, ng;
    int bits;
    if (n == 0) return 0;
    bits = 0;
    while (bits < 64 && (n >> bits) != 0) bits++;
    g = 64'd1 << ((bits + 1) / 2);
    for (int i = 0; i < 10; i++) begin
      ng = (g + n / g) / 2;
      if (ng >= g) break;
      g = ng;
    end
    return g;
  endfunction

  function automatic logic [7:0] intensity(longint s);
    return 8'(((s + 4096) * 255) / 8192);
  endfunction

  function automatic color_t plasma_color(pixel_t p);
    longint cx, cy, tf, rad, v, prod, ph;
    color_t c;
    cx = (longint'(p.pixel_x) * 4096) / 50;
    cy = (longint'(p.pixel_y) * 4096) / 50;
    tf = (longint'(p.time_ms) * 4096) / 1000;
    rad = isqrt_newton(cx * cx + cy * cy);
    v = sine_at(cx + tf) + sine_at(cy + tf / 2) + sine_at((cx + cy + tf) / 2)
        + sine_at(rad + tf);
    prod = v * PI_Q;
    ph = (prod >= 0) ? prod / 4096 : -((-prod + 4095) / 4096);
    c.red = intensity(sine_at(ph));
    c.green = intensity(sine_at(ph + THIRD_Q));
    c.blue = intensity(sine_at(ph + TWO_THIRD_Q));
    return c;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int sel;
    sel = $urandom_range(0, 9);
    p.pixel_x = (sel == 0) ? 8'($urandom) : 8'($urandom_range(0, 239));
    p.pixel_y = (sel == 1) ? 8'($urandom) : 8'($urandom_range(0, 239));
    p.time_ms = (sel < 5) ? 24'($urandom) : 24'($urandom_range(0, 60000));
    return p;
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      // the accepted pixel leaves the queue here, so the front is the next one
      if (in_tvalid && in_tready) begin
        expected_colors.push_back(plasma_color(pixel_t'(in_tdata)));
        void'(pending_pixels.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold current transfer
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_pixels.size() > 0 && !hold_sender) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_pixels[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks transfers, stalls on its own pattern
  always @(posedge clk) begin
    color_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 200) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= (stall_phase % 7) < 3;
      endcase
      if (out_tvalid && out_tready) begin
        got = color_t'(out_tdata);
        if (expected_colors.size() == 0) begin
          $error("unexpected color transfer %h", out_tdata);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            error_count++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            error_count++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    pixel_t p;
    error_count = 0;
    hold_sender = 1'b0;
    rst_n = 1'b0;
    fill_quarter_sine();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // corners, off-screen coordinates, long times
    pending_pixels.push_back('{24'd0, 8'd0, 8'd0});
    pending_pixels.push_back('{24'd0, 8'd239, 8'd239});
    pending_pixels.push_back('{24'd0, 8'd255, 8'd255});
    pending_pixels.push_back('{24'hFFFFFF, 8'd0, 8'd0});
    pending_pixels.push_back('{24'hFFFFFF, 8'd255, 8'd255});
    pending_pixels.push_back('{24'hFFFFFF, 8'd239, 8'd0});
    pending_pixels.push_back('{24'd1, 8'd0, 8'd239});
    pending_pixels.push_back('{24'd999, 8'd240, 8'd17});
    pending_pixels.push_back('{24'd1000, 8'd17, 8'd240});
    pending_pixels.push_back('{24'h800000, 8'd128, 8'd128});
    pending_pixels.push_back('{24'h7FFFFF, 8'd127, 8'd127});
    pending_pixels.push_back('{24'hAAAAAA, 8'hAA, 8'h55});
    pending_pixels.push_back('{24'h555555, 8'h55, 8'hAA});
    pending_pixels.push_back('{24'd1571, 8'd79, 8'd157});
    pending_pixels.push_back('{24'd3142, 8'd50, 8'd50});
    for (int i = 0; i < 8; i++)
      pending_pixels.push_back('{24'(6283 * i), 8'(i * 30), 8'(239 - i * 30)});

    // let everything drain once before the random part
    wait (pending_pixels.size() == 0);
    @(posedge clk);
    hold_sender = 1'b1;
    wait (expected_colors.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;

    for (int i = 0; i < 950; i++) begin
      p = random_pixel();
      pending_pixels.push_back(p);
    end

    wait (pending_pixels.size() == 0);
    wait (expected_colors.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
